// ===== rtl/rvdec_pkg.sv =====
package rvdec_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 32;

	// Configuration register indexes (paddr[3:2])
	localparam logic [1:0] CFG_NOC_OPCODE      = 2'd0;
	localparam logic [1:0] CFG_SIMD_ADD_OPCODE = 2'd1;
	localparam logic [1:0] CFG_SIMD_SUB_OPCODE = 2'd2;

	// Configuration reset values
	localparam logic [6:0] NOC_OPCODE_RST      = 7'd11;
	localparam logic [6:0] SIMD_ADD_OPCODE_RST = 7'd43;
	localparam logic [6:0] SIMD_SUB_OPCODE_RST = 7'd91;

	// Standard major opcodes
	localparam logic [6:0] OPC_NOP    = 7'h00;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;

	// funct7 codes
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// funct3 codes
	localparam logic [2:0] F3_JALR   = 3'd0;
	localparam logic [2:0] F3_BEQ    = 3'd0;
	localparam logic [2:0] F3_BNE    = 3'd1;
	localparam logic [2:0] F3_BLT    = 3'd4;
	localparam logic [2:0] F3_BGE    = 3'd5;
	localparam logic [2:0] F3_BLTU   = 3'd6;
	localparam logic [2:0] F3_BGEU   = 3'd7;
	localparam logic [2:0] F3_LB     = 3'd0;
	localparam logic [2:0] F3_LH     = 3'd1;
	localparam logic [2:0] F3_LW     = 3'd2;
	localparam logic [2:0] F3_LBU    = 3'd4;
	localparam logic [2:0] F3_LHU    = 3'd5;
	localparam logic [2:0] F3_SW     = 3'd2;
	localparam logic [2:0] F3_ADD    = 3'd0;
	localparam logic [2:0] F3_SLL    = 3'd1;
	localparam logic [2:0] F3_SLT    = 3'd2;
	localparam logic [2:0] F3_SLTU   = 3'd3;
	localparam logic [2:0] F3_XOR    = 3'd4;
	localparam logic [2:0] F3_SR     = 3'd5;
	localparam logic [2:0] F3_OR     = 3'd6;
	localparam logic [2:0] F3_AND    = 3'd7;
	localparam logic [2:0] F3_NOC_LD = 3'd0;
	localparam logic [2:0] F3_NOC_ST = 3'd1;

	// Internal operation numbers
	localparam logic [5:0] OP_NOP      = 6'd0;
	localparam logic [5:0] OP_LUI      = 6'd1;
	localparam logic [5:0] OP_AUIPC    = 6'd2;
	localparam logic [5:0] OP_JAL      = 6'd3;
	localparam logic [5:0] OP_JALR     = 6'd4;
	localparam logic [5:0] OP_BEQ      = 6'd5;
	localparam logic [5:0] OP_BNE      = 6'd6;
	localparam logic [5:0] OP_BLT      = 6'd7;
	localparam logic [5:0] OP_BGE      = 6'd8;
	localparam logic [5:0] OP_BLTU     = 6'd9;
	localparam logic [5:0] OP_BGEU     = 6'd10;
	localparam logic [5:0] OP_LB       = 6'd11;
	localparam logic [5:0] OP_LH       = 6'd12;
	localparam logic [5:0] OP_LW       = 6'd13;
	localparam logic [5:0] OP_LBU      = 6'd14;
	localparam logic [5:0] OP_LHU      = 6'd15;
	localparam logic [5:0] OP_SB       = 6'd16;
	localparam logic [5:0] OP_ADDI     = 6'd19;
	localparam logic [5:0] OP_SLTI     = 6'd20;
	localparam logic [5:0] OP_SLTIU    = 6'd21;
	localparam logic [5:0] OP_XORI     = 6'd22;
	localparam logic [5:0] OP_ORI      = 6'd23;
	localparam logic [5:0] OP_ANDI     = 6'd24;
	localparam logic [5:0] OP_SLLI     = 6'd25;
	localparam logic [5:0] OP_SRLI     = 6'd26;
	localparam logic [5:0] OP_SRAI     = 6'd27;
	localparam logic [5:0] OP_ADD      = 6'd28;
	localparam logic [5:0] OP_SUB      = 6'd29;
	localparam logic [5:0] OP_SLL      = 6'd30;
	localparam logic [5:0] OP_SLT      = 6'd31;
	localparam logic [5:0] OP_SLTU     = 6'd32;
	localparam logic [5:0] OP_XOR      = 6'd33;
	localparam logic [5:0] OP_SRL      = 6'd34;
	localparam logic [5:0] OP_SRA      = 6'd35;
	localparam logic [5:0] OP_OR       = 6'd36;
	localparam logic [5:0] OP_AND      = 6'd37;
	localparam logic [5:0] OP_NOC_LD   = 6'd38;
	localparam logic [5:0] OP_NOC_ST   = 6'd39;
	localparam logic [5:0] OP_SIMD_ADD = 6'd40;
	localparam logic [5:0] OP_SIMD_SUB = 6'd41;

	// Instruction class reported on the result
	typedef enum logic [3:0] {
		KIND_ALU    = 4'd0,
		KIND_LOAD   = 4'd1,
		KIND_STORE  = 4'd2,
		KIND_BRANCH = 4'd3,
		KIND_JAL    = 4'd4,
		KIND_JALR   = 4'd5,
		KIND_NOC    = 4'd6,
		KIND_SIMD   = 4'd7,
		KIND_NOP    = 4'd8
	} kind_t;

	// Which counter an instruction bumps
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_REG,
		CLS_MEM,
		CLS_NOC,
		CLS_SIMD
	} cls_t;

	typedef struct packed {
		logic [31:0] instr;
		logic [31:0] pc;
		logic [31:0] base_value;
	} in_item_t;

	typedef struct packed {
		logic        [5:0]  op_index;
		logic        [4:0]  dest_reg;
		logic        [4:0]  src1_reg;
		logic        [4:0]  src2_reg;
		logic signed [31:0] immediate;
		logic signed [31:0] redirect_value;
		kind_t              kind;
		logic               illegal;
		logic        [31:0] register_count;
		logic        [31:0] memory_count;
		logic        [31:0] noc_count;
		logic        [31:0] simd_count;
	} out_item_t;

	typedef struct packed {
		logic [6:0] noc_opcode;
		logic [6:0] simd_add_opcode;
		logic [6:0] simd_sub_opcode;
	} cfg_t;

	typedef struct packed {
		logic [31:0] register_count;
		logic [31:0] memory_count;
		logic [31:0] noc_count;
		logic [31:0] simd_count;
	} counts_t;

endpackage

// ===== rtl/rv32i_instruction_decoder.sv =====
// RV32I instruction decoder with programmable NOC and SIMD opcodes.
//
// Input channel (in_valid / in_stall / in_data): one beat carries the
// instruction word, its pc and the rs1 value used for the JALR target.
// Output channel (out_valid / out_stall / out_data): one result beat per
// input beat, in order, with the operation number, register fields,
// immediate, redirect value, class, illegal flag and the four class counters
// as they stand after this instruction.
// A beat accepted into the input register is decoded into the output register
// and shown on out_data from there; an output stall holds it in place.
// Throughput: one beat per cycle while the output is not stalled. The input
// register feeds a single level of decode logic into the output register;
// each stage advances when the next has room. When the receiver stalls, the
// result holds in the output register and one more beat is still taken into
// the input register; after that in_stall rises until the output drains.
// Reset clears both stages and the counters and loads the default custom
// opcodes (NOC 11, SIMD add 43, SIMD subtract 91).
// APB: registers at byte offsets 0x0 (NOC opcode), 0x4 (SIMD add opcode) and
// 0x8 (SIMD subtract opcode), bits 6:0; write only while the block is idle.
module rv32i_instruction_decoder import rvdec_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;
	counts_t   counts_q;
	cfg_t      cfg_q;
	out_item_t res;
	logic      adv_s1;
	logic      adv_s2;
	logic      cfg_wr;

	// Stage handshakes
	assign adv_s2    = !valid_s2 || !out_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign in_stall  = !adv_s1;
	assign out_valid = valid_s2;
	assign out_data  = item_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= in_data;
		end
	end

	rvdec_decode u_decode (
		.item   (item_s1),
		.cfg    (cfg_q),
		.counts (counts_q),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			item_s2 <= res;
		end
	end

	// Class counters advance as each beat is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (adv_s2 && valid_s1) begin
			counts_q.register_count <= res.register_count;
			counts_q.memory_count   <= res.memory_count;
			counts_q.noc_count      <= res.noc_count;
			counts_q.simd_count     <= res.simd_count;
		end
	end

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noc_opcode      <= NOC_OPCODE_RST;
			cfg_q.simd_add_opcode <= SIMD_ADD_OPCODE_RST;
			cfg_q.simd_sub_opcode <= SIMD_SUB_OPCODE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				CFG_NOC_OPCODE:      cfg_q.noc_opcode      <= pwdata[6:0];
				CFG_SIMD_ADD_OPCODE: cfg_q.simd_add_opcode <= pwdata[6:0];
				CFG_SIMD_SUB_OPCODE: cfg_q.simd_sub_opcode <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		case (paddr[3:2])
			CFG_NOC_OPCODE:      prdata = {25'd0, cfg_q.noc_opcode};
			CFG_SIMD_ADD_OPCODE: prdata = {25'd0, cfg_q.simd_add_opcode};
			CFG_SIMD_SUB_OPCODE: prdata = {25'd0, cfg_q.simd_sub_opcode};
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== rtl/rvdec_decode.sv =====
module rvdec_decode import rvdec_pkg::*; (
	input  in_item_t  item,
	input  cfg_t      cfg,
	input  counts_t   counts,
	output out_item_t res
);

	logic [31:0] w;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [4:0]  r1;
	logic [4:0]  r2;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] jalr_sum;

	logic [5:0]  op;
	logic [4:0]  dst;
	logic [4:0]  s1;
	logic [4:0]  s2;
	logic [31:0] imm;
	logic [31:0] redir;
	kind_t       kind;
	logic        bad;
	cls_t        cls;

	// Split the instruction word
	assign w   = item.instr;
	assign opc = w[6:0];
	assign f3  = w[14:12];
	assign f7  = w[31:25];
	assign rd  = w[11:7];
	assign r1  = w[19:15];
	assign r2  = w[24:20];

	// Immediate formats
	assign imm_i    = {{20{w[31]}}, w[31:20]};
	assign imm_s    = {{20{w[31]}}, w[31:25], w[11:7]};
	assign imm_b    = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	assign imm_j    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
	assign jalr_sum = item.base_value + imm_i;

	// Opcode and function decode; standard opcodes take priority
	always_comb begin
		op    = OP_NOP;
		dst   = '0;
		s1    = '0;
		s2    = '0;
		imm   = '0;
		redir = '0;
		kind  = KIND_NOP;
		bad   = 1'b0;
		cls   = CLS_NONE;
		case (opc)
			OPC_LUI: begin
				op = OP_LUI; dst = rd; imm = {w[31:12], 12'd0}; kind = KIND_ALU; cls = CLS_REG;
			end
			OPC_AUIPC: begin
				op = OP_AUIPC; dst = rd; imm = {12'd0, w[31:12]}; kind = KIND_ALU; cls = CLS_REG;
			end
			OPC_JAL: begin
				op = OP_JAL; dst = rd; imm = item.pc; redir = imm_j;
				kind = KIND_JAL; cls = CLS_REG;
			end
			OPC_JALR: begin
				if (f3 != F3_JALR) begin
					bad = 1'b1;
				end else begin
					op = OP_JALR; dst = rd; s1 = r1; imm = item.pc;
					redir = {jalr_sum[31:1], 1'b0}; kind = KIND_JALR; cls = CLS_REG;
				end
			end
			OPC_BRANCH: begin
				s1 = r1; s2 = r2; imm = imm_b; kind = KIND_BRANCH; cls = CLS_REG;
				case (f3)
					F3_BEQ:  op = OP_BEQ;
					F3_BNE:  op = OP_BNE;
					F3_BLT:  op = OP_BLT;
					F3_BGE:  op = OP_BGE;
					F3_BLTU: op = OP_BLTU;
					F3_BGEU: op = OP_BGEU;
					default: bad = 1'b1;
				endcase
			end
			OPC_LOAD: begin
				dst = rd; s1 = r1; imm = imm_i; kind = KIND_LOAD; cls = CLS_MEM;
				case (f3)
					F3_LB:   op = OP_LB;
					F3_LH:   op = OP_LH;
					F3_LW:   op = OP_LW;
					F3_LBU:  op = OP_LBU;
					F3_LHU:  op = OP_LHU;
					default: bad = 1'b1;
				endcase
			end
			OPC_STORE: begin
				s1 = r1; s2 = r2; imm = imm_s; kind = KIND_STORE; cls = CLS_MEM;
				op = OP_SB + {3'd0, f3};
				if (f3 > F3_SW) begin
					bad = 1'b1;
				end
			end
			OPC_OPIMM: begin
				dst = rd; s1 = r1; imm = imm_i; kind = KIND_ALU; cls = CLS_REG;
				case (f3)
					F3_ADD:  op = OP_ADDI;
					F3_SLT:  op = OP_SLTI;
					F3_SLTU: op = OP_SLTIU;
					F3_XOR:  op = OP_XORI;
					F3_OR:   op = OP_ORI;
					F3_AND:  op = OP_ANDI;
					F3_SLL: begin
						op  = OP_SLLI;
						imm = {27'd0, r2};
						bad = (f7 != F7_BASE);
					end
					F3_SR: begin
						imm = {27'd0, r2};
						if (f7 == F7_ALT) begin
							op = OP_SRAI;
						end else begin
							op  = OP_SRLI;
							bad = (f7 != F7_BASE);
						end
					end
					default: bad = 1'b1;
				endcase
			end
			OPC_OP: begin
				dst = rd; s1 = r1; s2 = r2; kind = KIND_ALU; cls = CLS_REG;
				case (f3)
					F3_ADD:  op = (f7 == F7_ALT) ? OP_SUB : OP_ADD;
					F3_SLL:  op = OP_SLL;
					F3_SLT:  op = OP_SLT;
					F3_SLTU: op = OP_SLTU;
					F3_XOR:  op = OP_XOR;
					F3_SR:   op = (f7 == F7_ALT) ? OP_SRA : OP_SRL;
					F3_OR:   op = OP_OR;
					F3_AND:  op = OP_AND;
					default: bad = 1'b1;
				endcase
				if (f7 == F7_ALT) begin
					if (f3 != F3_ADD && f3 != F3_SR) begin
						bad = 1'b1;
					end
				end else if (f7 != F7_BASE) begin
					bad = 1'b1;
				end
			end
			default: begin
				// Opcode zero, then the programmable custom opcodes
				if (opc == OPC_NOP) begin
					kind = KIND_NOP;
				end else if (opc == cfg.noc_opcode) begin
					kind = KIND_NOC; cls = CLS_NOC;
					if (f3 == F3_NOC_LD) begin
						op = OP_NOC_LD; s1 = r1; s2 = r2; imm = imm_s;
					end else if (f3 == F3_NOC_ST) begin
						op = OP_NOC_ST; imm = 32'd1;
					end else begin
						bad = 1'b1;
					end
				end else if (opc == cfg.simd_add_opcode || opc == cfg.simd_sub_opcode) begin
					op   = (opc == cfg.simd_add_opcode) ? OP_SIMD_ADD : OP_SIMD_SUB;
					dst  = rd; s1 = r1; s2 = r2; kind = KIND_SIMD; cls = CLS_SIMD;
				end else begin
					bad = 1'b1;
				end
			end
		endcase
		// Illegal words report nothing and count nowhere
		if (bad) begin
			op    = OP_NOP;
			dst   = '0;
			s1    = '0;
			s2    = '0;
			imm   = '0;
			redir = '0;
			kind  = KIND_NOP;
			cls   = CLS_NONE;
		end
	end

	// Result beat with counters after this instruction
	always_comb begin
		res.op_index       = op;
		res.dest_reg       = dst;
		res.src1_reg       = s1;
		res.src2_reg       = s2;
		res.immediate      = imm;
		res.redirect_value = redir;
		res.kind           = kind;
		res.illegal        = bad;
		res.register_count = counts.register_count + {31'd0, cls == CLS_REG};
		res.memory_count   = counts.memory_count + {31'd0, cls == CLS_MEM};
		res.noc_count      = counts.noc_count + {31'd0, cls == CLS_NOC};
		res.simd_count     = counts.simd_count + {31'd0, cls == CLS_SIMD};
	end

endmodule

// ===== rtl/rvdec_checker.sv =====
module rvdec_checker import rvdec_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input in_item_t              in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input out_item_t             out_data,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [CFG_DATA_W-1:0] pwdata,
	input logic [CFG_DATA_W-1:0] prdata,
	input logic                  pready
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// Back-pressure the input only when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// Drop the operation, kind, immediate and redirect of an illegal word
	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.illegal |-> out_data.op_index == OP_NOP &&
			out_data.kind == KIND_NOP && out_data.immediate == 0 &&
			out_data.redirect_value == 0)
		else $error("illegal beat carries decoded fields");

	// Redirect only on jumps; JALR target is halfword aligned
	a_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.kind == KIND_JAL || out_data.kind == KIND_JALR ||
			out_data.redirect_value == 0) &&
			(out_data.kind != KIND_JALR || !out_data.redirect_value[0]))
		else $error("bad redirect value");

endmodule

bind rv32i_instruction_decoder rvdec_checker u_checker (.*);

// ===== sim/rv32i_instruction_decoder_tb.sv =====
`timescale 1ns / 1ps

module rv32i_instruction_decoder_tb import rvdec_pkg::*;;

	localparam int unsigned NUM_MAPS      = 8;
	localparam int unsigned ITEMS_PER_MAP = 160;
	localparam int unsigned DRAIN_MAP     = 3;
	localparam int unsigned CYCLE_LIMIT   = 250000;

	// Reserved encodings used to provoke the illegal flag, plus immediate top bits and a spare opcode
	localparam logic [2:0] F3_JALR_RSVD   = 3'd4;
	localparam logic [2:0] F3_BRANCH_RSVD = 3'd2;
	localparam logic [2:0] F3_LOAD_RSVD   = 3'd3;
	localparam logic [2:0] F3_STORE_RSVD  = 3'd3;
	localparam logic [2:0] F3_NOC_RSVD    = 3'd2;
	localparam logic [6:0] F7_RSVD        = 7'h01;
	localparam logic [6:0] IMM_HI_NEG     = 7'h7f;
	localparam logic [6:0] IMM_HI_POS     = 7'h3f;
	localparam logic [6:0] OPC_SPARE      = 7'd123;

	// Expected decode results, kept in the order the beats went in
	class decode_scoreboard;
		cfg_t        opcode_map;
		counts_t     class_counts;
		out_item_t   pending_decodes[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned noted;
		int unsigned illegal_seen;

		function new();
			opcode_map = '{NOC_OPCODE_RST, SIMD_ADD_OPCODE_RST, SIMD_SUB_OPCODE_RST};
			class_counts = '0;
			mismatches = 0;
			checked = 0;
			noted = 0;
			illegal_seen = 0;
		endfunction

		function out_item_t decode(in_item_t it);
			out_item_t   r;
			logic [31:0] w;
			logic [6:0]  opc;
			logic [6:0]  f7;
			logic [2:0]  f3;
			logic [4:0]  rd;
			logic [4:0]  rs1;
			logic [4:0]  rs2;
			logic [31:0] i_imm;
			logic [31:0] s_imm;
			logic [31:0] b_imm;
			logic [31:0] j_imm;
			cls_t        cls;
			logic        bad;
			w = it.instr;
			opc = w[6:0];
			f3 = w[14:12];
			f7 = w[31:25];
			rd = w[11:7];
			rs1 = w[19:15];
			rs2 = w[24:20];
			i_imm = {{20{w[31]}}, w[31:20]};
			s_imm = {{20{w[31]}}, w[31:25], w[11:7]};
			b_imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			j_imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			r = '0;
			r.kind = KIND_NOP;
			cls = CLS_NONE;
			bad = 1'b0;

			case (opc)
				OPC_LUI: begin
					r.op_index = OP_LUI;
					r.dest_reg = rd;
					r.immediate = {w[31:12], 12'h000};
					r.kind = KIND_ALU;
					cls = CLS_REG;
				end
				OPC_AUIPC: begin
					r.op_index = OP_AUIPC;
					r.dest_reg = rd;
					r.immediate = {12'h000, w[31:12]};
					r.kind = KIND_ALU;
					cls = CLS_REG;
				end
				OPC_JAL: begin
					r.op_index = OP_JAL;
					r.dest_reg = rd;
					r.immediate = it.pc;
					r.redirect_value = j_imm;
					r.kind = KIND_JAL;
					cls = CLS_REG;
				end
				OPC_JALR: begin
					if (f3 != F3_JALR) begin
						bad = 1'b1;
					end else begin
						r.op_index = OP_JALR;
						r.dest_reg = rd;
						r.src1_reg = rs1;
						r.immediate = it.pc;
						r.redirect_value = (it.base_value + i_imm) & ~32'd1;
						r.kind = KIND_JALR;
						cls = CLS_REG;
					end
				end
				OPC_BRANCH: begin
					case (f3)
						F3_BEQ:  r.op_index = OP_BEQ;
						F3_BNE:  r.op_index = OP_BNE;
						F3_BLT:  r.op_index = OP_BLT;
						F3_BGE:  r.op_index = OP_BGE;
						F3_BLTU: r.op_index = OP_BLTU;
						F3_BGEU: r.op_index = OP_BGEU;
						default: bad = 1'b1;
					endcase
					r.src1_reg = rs1;
					r.src2_reg = rs2;
					r.immediate = b_imm;
					r.kind = KIND_BRANCH;
					cls = CLS_REG;
				end
				OPC_LOAD: begin
					case (f3)
						F3_LB:   r.op_index = OP_LB;
						F3_LH:   r.op_index = OP_LH;
						F3_LW:   r.op_index = OP_LW;
						F3_LBU:  r.op_index = OP_LBU;
						F3_LHU:  r.op_index = OP_LHU;
						default: bad = 1'b1;
					endcase
					r.dest_reg = rd;
					r.src1_reg = rs1;
					r.immediate = i_imm;
					r.kind = KIND_LOAD;
					cls = CLS_MEM;
				end
				OPC_STORE: begin
					if (f3 > F3_SW) bad = 1'b1;
					r.op_index = OP_SB + {3'b000, f3};
					r.src1_reg = rs1;
					r.src2_reg = rs2;
					r.immediate = s_imm;
					r.kind = KIND_STORE;
					cls = CLS_MEM;
				end
				OPC_OPIMM: begin
					r.immediate = i_imm;
					case (f3)
						F3_ADD:  r.op_index = OP_ADDI;
						F3_SLT:  r.op_index = OP_SLTI;
						F3_SLTU: r.op_index = OP_SLTIU;
						F3_XOR:  r.op_index = OP_XORI;
						F3_OR:   r.op_index = OP_ORI;
						F3_AND:  r.op_index = OP_ANDI;
						F3_SLL: begin
							r.op_index = OP_SLLI;
							r.immediate = {27'd0, rs2};
							if (f7 != F7_BASE) bad = 1'b1;
						end
						default: begin
							// right shifts: funct7 picks logical or arithmetic
							r.op_index = (f7 == F7_ALT) ? OP_SRAI : OP_SRLI;
							r.immediate = {27'd0, rs2};
							if (f7 != F7_BASE && f7 != F7_ALT) bad = 1'b1;
						end
					endcase
					r.dest_reg = rd;
					r.src1_reg = rs1;
					r.kind = KIND_ALU;
					cls = CLS_REG;
				end
				OPC_OP: begin
					case (f3)
						F3_ADD:  r.op_index = OP_ADD;
						F3_SLL:  r.op_index = OP_SLL;
						F3_SLT:  r.op_index = OP_SLT;
						F3_SLTU: r.op_index = OP_SLTU;
						F3_XOR:  r.op_index = OP_XOR;
						F3_SR:   r.op_index = OP_SRL;
						F3_OR:   r.op_index = OP_OR;
						default: r.op_index = OP_AND;
					endcase
					if (f7 == F7_ALT && f3 == F3_ADD) r.op_index = OP_SUB;
					else if (f7 == F7_ALT && f3 == F3_SR) r.op_index = OP_SRA;
					else if (f7 != F7_BASE) bad = 1'b1;
					r.dest_reg = rd;
					r.src1_reg = rs1;
					r.src2_reg = rs2;
					r.kind = KIND_ALU;
					cls = CLS_REG;
				end
				OPC_NOP: ;
				default: begin
					// programmable opcodes rank below the standard ones and nop
					if (opc == opcode_map.noc_opcode) begin
						if (f3 == F3_NOC_LD) begin
							r.op_index = OP_NOC_LD;
							r.src1_reg = rs1;
							r.src2_reg = rs2;
							r.immediate = s_imm;
						end else if (f3 == F3_NOC_ST) begin
							r.op_index = OP_NOC_ST;
							r.immediate = 32'd1;
						end else begin
							bad = 1'b1;
						end
						r.kind = KIND_NOC;
						cls = CLS_NOC;
					end else if (opc == opcode_map.simd_add_opcode ||
						opc == opcode_map.simd_sub_opcode) begin
						r.op_index = (opc == opcode_map.simd_add_opcode) ? OP_SIMD_ADD : OP_SIMD_SUB;
						r.dest_reg = rd;
						r.src1_reg = rs1;
						r.src2_reg = rs2;
						r.kind = KIND_SIMD;
						cls = CLS_SIMD;
					end else begin
						bad = 1'b1;
					end
				end
			endcase

			// an illegal word clears every field and counts nowhere
			if (bad) begin
				r = '0;
				r.kind = KIND_NOP;
				r.illegal = 1'b1;
				cls = CLS_NONE;
				illegal_seen++;
			end
			case (cls)
				CLS_REG:  class_counts.register_count++;
				CLS_MEM:  class_counts.memory_count++;
				CLS_NOC:  class_counts.noc_count++;
				CLS_SIMD: class_counts.simd_count++;
				default: ;
			endcase
			r.register_count = class_counts.register_count;
			r.memory_count = class_counts.memory_count;
			r.noc_count = class_counts.noc_count;
			r.simd_count = class_counts.simd_count;
			return r;
		endfunction

		function void note_input(in_item_t it);
			pending_decodes.push_back(decode(it));
			noted++;
		endfunction

		function int unsigned pending();
			return pending_decodes.size();
		endfunction

		task report(string msg);
			if (mismatches < 100) $display("MISMATCH @%0t: %s", $time, msg);
			mismatches++;
		endtask

		task field_check(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("beat %0d %s got 0x%08h want 0x%08h", checked, name, got, want));
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending_decodes.size() == 0) begin
				report("result beat with no decode pending");
				return;
			end
			want = pending_decodes.pop_front();
			field_check("op_index", got.op_index, want.op_index);
			field_check("dest_reg", got.dest_reg, want.dest_reg);
			field_check("src1_reg", got.src1_reg, want.src1_reg);
			field_check("src2_reg", got.src2_reg, want.src2_reg);
			field_check("immediate", got.immediate, want.immediate);
			field_check("redirect_value", got.redirect_value, want.redirect_value);
			field_check("kind", got.kind, want.kind);
			field_check("illegal", got.illegal, want.illegal);
			field_check("register_count", got.register_count, want.register_count);
			field_check("memory_count", got.memory_count, want.memory_count);
			field_check("noc_count", got.noc_count, want.noc_count);
			field_check("simd_count", got.simd_count, want.simd_count);
			checked++;
		endtask
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	decode_scoreboard sb = new();
	bit               bubbles_on = 1'b0;
	logic [3:0]       stall_left = '0;
	int unsigned      cycles = 0;
	cfg_t             maps[NUM_MAPS];

	rv32i_instruction_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending", cycles, sb.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Take result beats and stall the output in random bursts
	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_result(out_data);
		if (bubbles_on && stall_left != 0) begin
			stall_left <= stall_left - 1'b1;
			out_stall <= 1'b1;
		end else if (bubbles_on && $urandom_range(0, 7) == 0) begin
			stall_left <= 4'($urandom_range(0, 15));
			out_stall <= 1'b1;
		end else begin
			stall_left <= '0;
			out_stall <= 1'b0;
		end
	end

	function automatic logic [31:0] corner_value(int unsigned k);
		case (k % 4)
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			default: return 32'h7fff_ffff;
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 7) == 0) return corner_value($urandom_range(0, 3));
		return $urandom;
	endfunction

	// Random register fields and immediates around a chosen opcode and functs
	function automatic logic [31:0] make_word(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7);
		logic [31:0] w;
		w = $urandom;
		w[6:0] = opc;
		w[14:12] = f3;
		w[31:25] = f7;
		return w;
	endfunction

	function automatic logic [31:0] random_word(cfg_t m);
		logic [31:0] w;
		logic [6:0]  menu[16];
		int unsigned pick;
		w = $urandom;
		pick = $urandom_range(0, 16);
		menu = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
			OPC_OPIMM, OPC_OPIMM, OPC_OP, OPC_OP, OPC_NOP, m.noc_opcode, m.noc_opcode,
			m.simd_add_opcode, m.simd_sub_opcode};
		if (pick < 16) w[6:0] = menu[pick];
		// lean toward legal funct fields, keep the rest as noise
		if ($urandom_range(0, 3) != 0) begin
			if (w[6:0] == OPC_JALR) w[14:12] = F3_JALR;
			else if (w[6:0] == OPC_STORE) w[14:12] = 3'($urandom_range(F3_SW));
			else if (w[6:0] == m.noc_opcode)
				w[14:12] = 3'($urandom_range(F3_NOC_LD, F3_NOC_ST));
			if (w[6:0] == OPC_OP || (w[6:0] == OPC_OPIMM &&
				(w[14:12] == F3_SLL || w[14:12] == F3_SR)))
				w[31:25] = ($urandom_range(0, 2) == 0) ? F7_ALT : F7_BASE;
		end
		return w;
	endfunction

	// Hold the beat until the decoder takes it
	task automatic send_beat(in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic feed(in_item_t it);
		send_beat(it);
		if (bubbles_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Setup and access phase; the caller drops psel after the last write
	task automatic apb_write(logic [1:0] idx, logic [6:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic program_map(cfg_t m);
		apb_write(CFG_NOC_OPCODE, m.noc_opcode);
		apb_write(CFG_SIMD_ADD_OPCODE, m.simd_add_opcode);
		apb_write(CFG_SIMD_SUB_OPCODE, m.simd_sub_opcode);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.opcode_map = m;
	endtask

	initial begin
		logic [31:0] dir_words[$];
		in_item_t    beat;
		int unsigned mi;
		int unsigned n;

		// Opcode maps: reset defaults, extremes, and every overlap order
		maps[0] = '{NOC_OPCODE_RST, SIMD_ADD_OPCODE_RST, SIMD_SUB_OPCODE_RST};
		maps[1] = '{7'd127, 7'd0, 7'd127};
		maps[2] = '{7'd0, 7'd127, OPC_OP};
		maps[3] = '{SIMD_ADD_OPCODE_RST, SIMD_ADD_OPCODE_RST, SIMD_SUB_OPCODE_RST};
		maps[4] = '{NOC_OPCODE_RST, OPC_SPARE, OPC_SPARE};
		for (mi = 5; mi < NUM_MAPS; mi++)
			maps[mi] = '{7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127))};

		// Directed words under the reset map
		dir_words.push_back(32'h0000_0000);
		dir_words.push_back(32'hffff_ffff);
		dir_words.push_back(make_word(OPC_LUI, F3_AND, IMM_HI_NEG));
		dir_words.push_back(make_word(OPC_AUIPC, F3_ADD, IMM_HI_NEG));
		dir_words.push_back(make_word(OPC_JAL, F3_SR, IMM_HI_NEG));
		dir_words.push_back(make_word(OPC_JAL, F3_SLT, F7_BASE));
		dir_words.push_back(make_word(OPC_JALR, F3_JALR, IMM_HI_POS));
		dir_words.push_back(make_word(OPC_JALR, F3_JALR_RSVD, F7_BASE));
		dir_words.push_back(make_word(OPC_BRANCH, F3_BEQ, IMM_HI_NEG));
		dir_words.push_back(make_word(OPC_BRANCH, F3_BGEU, F7_BASE));
		dir_words.push_back(make_word(OPC_BRANCH, F3_BRANCH_RSVD, F7_BASE));
		dir_words.push_back(make_word(OPC_LOAD, F3_LB, IMM_HI_NEG));
		dir_words.push_back(make_word(OPC_LOAD, F3_LHU, IMM_HI_POS));
		dir_words.push_back(make_word(OPC_LOAD, F3_LOAD_RSVD, F7_BASE));
		dir_words.push_back(make_word(OPC_STORE, F3_SW, IMM_HI_NEG));
		dir_words.push_back(make_word(OPC_STORE, F3_STORE_RSVD, F7_BASE));
		dir_words.push_back(make_word(OPC_OPIMM, F3_ADD, IMM_HI_NEG));
		dir_words.push_back(make_word(OPC_OPIMM, F3_SLL, F7_BASE));
		dir_words.push_back(make_word(OPC_OPIMM, F3_SR, F7_ALT));
		dir_words.push_back(make_word(OPC_OPIMM, F3_SR, F7_RSVD));
		dir_words.push_back(make_word(OPC_OP, F3_ADD, F7_ALT));
		dir_words.push_back(make_word(OPC_OP, F3_SR, F7_ALT));
		dir_words.push_back(make_word(OPC_OP, F3_AND, F7_BASE));
		dir_words.push_back(make_word(OPC_OP, F3_XOR, F7_ALT));
		dir_words.push_back(make_word(NOC_OPCODE_RST, F3_NOC_LD, IMM_HI_NEG));
		dir_words.push_back(make_word(NOC_OPCODE_RST, F3_NOC_ST, IMM_HI_NEG));
		dir_words.push_back(make_word(NOC_OPCODE_RST, F3_NOC_RSVD, F7_BASE));
		dir_words.push_back(make_word(SIMD_ADD_OPCODE_RST, F3_ADD, IMM_HI_NEG));
		dir_words.push_back(make_word(SIMD_SUB_OPCODE_RST, F3_AND, F7_BASE));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (mi = 0; mi < NUM_MAPS; mi++) begin
			if (mi > 0) begin
				drain_results();
				program_map(maps[mi]);
			end
			bubbles_on = (mi != NUM_MAPS - 1);
			if (mi == 0) begin
				for (n = 0; n < dir_words.size(); n++) begin
					beat.instr = dir_words[n];
					beat.pc = corner_value(n);
					beat.base_value = corner_value(n + 1);
					feed(beat);
				end
			end
			for (n = 0; n < ITEMS_PER_MAP; n++) begin
				// alternate stretches with and without bubbles
				if (n % 40 == 0 && mi != NUM_MAPS - 1) bubbles_on = ($urandom_range(0, 2) != 0);
				if (mi == DRAIN_MAP && n == ITEMS_PER_MAP / 2) drain_results();
				beat.instr = random_word(sb.opcode_map);
				beat.pc = pick_value();
				beat.base_value = pick_value();
				feed(beat);
			end
		end

		// Let the last results out, then watch for strays
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) sb.report("decodes never delivered");

		$display("Decoded %0d instruction beats under %0d opcode maps, %0d illegal.",
			sb.noted, NUM_MAPS, sb.illegal_seen);
		$display("Class counters ended at register %0d, memory %0d, noc %0d, simd %0d.",
			sb.class_counts.register_count, sb.class_counts.memory_count,
			sb.class_counts.noc_count, sb.class_counts.simd_count);
		if (sb.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rvdec_pkg.sv
rtl/rvdec_decode.sv
rtl/rv32i_instruction_decoder.sv
rtl/rvdec_checker.sv
sim/rv32i_instruction_decoder_tb.sv
